// ===== sv/bdpb_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpb_pkg
// Shared types, register indexes and reset values for the bright defect
// pixel blanking block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpb_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int MIN_DIM       = 4;

  localparam int PIX_W   = 8;
  localparam int BTHR_W  = 10;
  localparam int RTHR_W  = 12;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 25;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Register indexes on the configuration port.
  localparam logic [CIDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BTHR   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_RTHR   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 3'd4;

  // Mode codes; the other two codes pass pixels through.
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_BLOCK  = 2'd2;

  localparam logic [1:0]        MODE_RST   = MODE_SINGLE;
  localparam logic [BTHR_W-1:0] BTHR_RST   = 10'd200;
  localparam logic [RTHR_W-1:0] RTHR_RST   = 12'd0;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd4096;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd4096;

  // One column of the four buffered rows, one byte per row slot.
  typedef logic [3:0][PIX_W-1:0] col_t;

endpackage

`default_nettype wire

// ===== sv/bdpb_if.sv =====
// ----------------------------------------------------------------------------
// bdpb stream interfaces
// Valid/ready channels for the pixel input and the corrected pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdpb_in_if;
  logic                      valid;
  logic                      ready;
  logic [bdpb_pkg::PIX_W-1:0] pixel_in;
  logic                      is_flush;
  modport source (output valid, pixel_in, is_flush, input ready);
  modport sink   (input valid, pixel_in, is_flush, output ready);
endinterface

interface bdpb_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdpb_pkg::PIX_W-1:0] pixel_out;
  logic                       was_blanked;
  logic                       frame_last;
  logic [bdpb_pkg::CNT_W-1:0] defect_count;
  modport source (output valid, pixel_out, was_blanked, frame_last, defect_count,
                  input ready);
  modport sink   (input valid, pixel_out, was_blanked, frame_last, defect_count,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/bright_defect_pixel_blanking_core.sv =====
// ----------------------------------------------------------------------------
// bright_defect_pixel_blanking_core
// Pipeline: a result is registered through stages B, C and D and the output
// register; in items, pixel n comes out on frame item n + 2*W + 2.
// Throughput: one item per cycle unless the output stalls, set by the column
// word memory, which takes one byte write and one word read per cycle.
// Reset: synchronous active-low rst_n clears counters and valids; the memories
// are not cleared because no entry is read before it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module bright_defect_pixel_blanking_core #(
  parameter int MAX_WIDTH = bdpb_pkg::MAX_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  bdpb_in_if.sink                      in_if,
  bdpb_out_if.source                   out_if,
  input  wire                          cfg_we,
  input  wire [bdpb_pkg::CIDX_W-1:0]   cfg_index,
  input  wire [bdpb_pkg::CFG_W-1:0]    cfg_data
);

  // Column address width and effective-width width.
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  // --------------------------------------------------------------------------
  // Configuration registers. A dimension write restarts the frame.
  // --------------------------------------------------------------------------
  logic [1:0]                     mode_r;
  logic [bdpb_pkg::BTHR_W-1:0]    bthr_r;
  logic [bdpb_pkg::RTHR_W-1:0]    rthr_r;
  logic [bdpb_pkg::DIM_W-1:0]     width_r;
  logic [bdpb_pkg::DIM_W-1:0]     height_r;
  logic                           restart;

  assign restart = cfg_we && ((cfg_index == bdpb_pkg::CFG_WIDTH) ||
                              (cfg_index == bdpb_pkg::CFG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bdpb_pkg::MODE_RST;
      bthr_r   <= bdpb_pkg::BTHR_RST;
      rthr_r   <= bdpb_pkg::RTHR_RST;
      width_r  <= bdpb_pkg::WIDTH_RST;
      height_r <= bdpb_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdpb_pkg::CFG_MODE:   mode_r   <= cfg_data[1:0];
        bdpb_pkg::CFG_BTHR:   bthr_r   <= cfg_data[bdpb_pkg::BTHR_W-1:0];
        bdpb_pkg::CFG_RTHR:   rthr_r   <= cfg_data[bdpb_pkg::RTHR_W-1:0];
        bdpb_pkg::CFG_WIDTH:  width_r  <= cfg_data;
        bdpb_pkg::CFG_HEIGHT: height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Dimensions clamped to the supported range.
  logic [WW-1:0]                  w_eff;
  logic [bdpb_pkg::DIM_W-1:0]     h_eff;

  always_comb begin
    logic [31:0] wv;
    logic [31:0] hv;
    wv = 32'(width_r);
    hv = 32'(height_r);
    if (wv < 32'(bdpb_pkg::MIN_DIM)) wv = 32'(bdpb_pkg::MIN_DIM);
    if (wv > 32'(MAX_WIDTH)) wv = 32'(MAX_WIDTH);
    if (hv < 32'(bdpb_pkg::MIN_DIM)) hv = 32'(bdpb_pkg::MIN_DIM);
    if (hv > 32'(bdpb_pkg::HEIGHT_LIMIT)) hv = 32'(bdpb_pkg::HEIGHT_LIMIT);
    w_eff = wv[WW-1:0];
    h_eff = hv[bdpb_pkg::DIM_W-1:0];
  end

  logic [WW-1:0]              w_m1;
  logic [WW-1:0]              w_m2;
  logic [bdpb_pkg::DIM_W-1:0] h_m1;
  logic [bdpb_pkg::DIM_W-1:0] h_m2;

  assign w_m1 = w_eff - WW'(1);
  assign w_m2 = w_eff - WW'(2);
  assign h_m1 = h_eff - bdpb_pkg::DIM_W'(1);
  assign h_m2 = h_eff - bdpb_pkg::DIM_W'(2);

  // --------------------------------------------------------------------------
  // Pipeline enable. Every stage moves together; the output register is the
  // only place where a finished item waits, so the input stays open whenever
  // the output register is empty or being drained.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic en;

  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // --------------------------------------------------------------------------
  // Stage A: frame position, row memory write and column word read.
  // The input position runs 2*W+2 items ahead of the emitted position.
  // --------------------------------------------------------------------------
  logic [CW-1:0]               col_cnt_r;
  logic [bdpb_pkg::DIM_W-1:0]  row_cnt_r;
  logic [CW-1:0]               ox_r;
  logic [bdpb_pkg::DIM_W-2:0]  oy_r;

  logic pix_phase;
  logic take;
  logic emit_a;
  logic last_a;

  assign pix_phase = row_cnt_r < h_eff;
  // A flush item inside the pixel phase is accepted and dropped.
  assign take      = in_if.valid && en && !(pix_phase && in_if.is_flush);
  assign emit_a    = (row_cnt_r > bdpb_pkg::DIM_W'(2)) ||
                     ((row_cnt_r == bdpb_pkg::DIM_W'(2)) && (col_cnt_r >= CW'(2)));
  assign last_a    = emit_a && ({1'b0, ox_r} == w_m1) && ({1'b0, oy_r} == h_m1);

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      ox_r      <= '0;
      oy_r      <= '0;
    end else if (take) begin
      if (last_a) begin
        col_cnt_r <= '0;
        row_cnt_r <= '0;
        ox_r      <= '0;
        oy_r      <= '0;
      end else begin
        if ({1'b0, col_cnt_r} == w_m1) begin
          col_cnt_r <= '0;
          row_cnt_r <= row_cnt_r + bdpb_pkg::DIM_W'(1);
        end else begin
          col_cnt_r <= col_cnt_r + CW'(1);
        end
        if (emit_a) begin
          if ({1'b0, ox_r} == w_m1) begin
            ox_r <= '0;
            oy_r <= oy_r + (bdpb_pkg::DIM_W-1)'(1);
          end else begin
            ox_r <= ox_r + CW'(1);
          end
        end
      end
    end
  end

  // Row memory: one word per column, one byte lane per buffered row.
  bdpb_pkg::col_t row_mem [MAX_WIDTH];
  bdpb_pkg::col_t rd_word_r;

  always_ff @(posedge clk) begin
    if (take && pix_phase) begin
      row_mem[col_cnt_r][row_cnt_r[1:0]] <= in_if.pixel_in;
    end
    if (en) begin
      rd_word_r <= row_mem[col_cnt_r];
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: merge the byte written in the same cycle as the read, then shift
  // the finished column into the 4-column window.
  // --------------------------------------------------------------------------
  logic                        b_valid_r;
  logic                        b_emit_r;
  logic                        b_merge_r;
  logic [1:0]                  b_lane_r;
  logic [bdpb_pkg::PIX_W-1:0]  b_px_r;
  logic [CW-1:0]               b_x_r;
  logic [bdpb_pkg::DIM_W-2:0]  b_y_r;
  logic                        b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_emit_r  <= emit_a;
      b_merge_r <= pix_phase;
      b_lane_r  <= row_cnt_r[1:0];
      b_px_r    <= in_if.pixel_in;
      b_x_r     <= ox_r;
      b_y_r     <= oy_r;
      b_last_r  <= last_a;
    end
  end

  bdpb_pkg::col_t b_word;

  always_comb begin
    b_word = rd_word_r;
    if (b_merge_r) begin
      b_word[b_lane_r] = b_px_r;
    end
  end

  // win_r[0] holds column x-1 of the item in stage C, win_r[3] column x+2.
  bdpb_pkg::col_t win_r [4];

  always_ff @(posedge clk) begin
    if (en && b_valid_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= b_word;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: mirror the 4x4 neighbourhood at the frame borders and form the
  // sums. Edges mirror without repeating the edge pixel.
  // --------------------------------------------------------------------------
  logic                        c_valid_r;
  logic [CW-1:0]               c_x_r;
  logic [bdpb_pkg::DIM_W-2:0]  c_y_r;
  logic                        c_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r && b_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x_r    <= b_x_r;
      c_y_r    <= b_y_r;
      c_last_r <= b_last_r;
    end
  end

  logic [bdpb_pkg::PIX_W-1:0] c_center;
  logic [10:0]                c_ring1;
  logic [9:0]                 c_inner;
  logic [11:0]                c_ring2;
  logic                       c_blk_ok;

  always_comb begin
    logic [1:0]                 cs [4];
    logic [1:0]                 rl [4];
    logic [1:0]                 rs [4];
    logic [bdpb_pkg::PIX_W-1:0] p  [4][4];
    logic [11:0]                sum9;
    logic [11:0]                sum16;
    logic [9:0]                 inner;
    // Column mirror: x-1 at the left edge, x+1 and x+2 at the right edge.
    cs[0] = (c_x_r == '0) ? 2'd2 : 2'd0;
    cs[1] = 2'd1;
    cs[2] = ({1'b0, c_x_r} == w_m1) ? 2'd0 : 2'd2;
    cs[3] = ({1'b0, c_x_r} == w_m2) ? 2'd1 : 2'd3;
    // Row slots of rows y-1..y+2, then the same mirror at top and bottom.
    for (int r = 0; r < 4; r++) begin
      rl[r] = c_y_r[1:0] + 2'(r) - 2'd1;
    end
    rs[0] = (c_y_r == '0) ? rl[2] : rl[0];
    rs[1] = rl[1];
    rs[2] = ({1'b0, c_y_r} == h_m1) ? rl[0] : rl[2];
    rs[3] = ({1'b0, c_y_r} == h_m2) ? rl[1] : rl[3];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        p[r][c] = win_r[cs[c]][rs[r]];
      end
    end
    sum9  = '0;
    sum16 = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sum16 = sum16 + 12'(p[r][c]);
        if (r < 3 && c < 3) begin
          sum9 = sum9 + 12'(p[r][c]);
        end
      end
    end
    inner    = 10'(p[1][1]) + 10'(p[1][2]) + 10'(p[2][1]) + 10'(p[2][2]);
    c_center = p[1][1];
    c_ring1  = 11'(sum9 - 12'(p[1][1]));
    c_inner  = inner;
    c_ring2  = sum16 - 12'(inner);
    // A block exists only when its bottom-right pixel lies inside the frame.
    c_blk_ok = ({1'b0, c_x_r} <= w_m2) && ({1'b0, c_y_r} <= h_m2);
  end

  // --------------------------------------------------------------------------
  // Stage D: decisions. The flag memory holds, per column, the block decision
  // of the previous emitted row; the left and diagonal flags come from the
  // previous item.
  // --------------------------------------------------------------------------
  logic                        d_valid_r;
  logic [CW-1:0]               d_x_r;
  logic [bdpb_pkg::DIM_W-2:0]  d_y_r;
  logic                        d_last_r;
  logic [bdpb_pkg::PIX_W-1:0]  d_center_r;
  logic [10:0]                 d_ring1_r;
  logic [9:0]                  d_inner_r;
  logic [11:0]                 d_ring2_r;
  logic                        d_blk_ok_r;
  logic                        flag_rd_r;
  logic                        left_r;
  logic                        diag_r;
  logic [bdpb_pkg::CNT_W-1:0]  total_r;

  logic flag_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_x_r      <= c_x_r;
      d_y_r      <= c_y_r;
      d_last_r   <= c_last_r;
      d_center_r <= c_center;
      d_ring1_r  <= c_ring1;
      d_inner_r  <= c_inner;
      d_ring2_r  <= c_ring2;
      d_blk_ok_r <= c_blk_ok;
      flag_rd_r  <= flag_mem[c_x_r];
    end
  end

  logic                       cur;
  logic                       up;
  logic                       left;
  logic                       diag;
  logic                       blank;
  logic                       found;
  logic [bdpb_pkg::CNT_W-1:0] total_nxt;

  always_comb begin
    cur  = d_blk_ok_r && (d_inner_r >= bthr_r) && (d_ring2_r <= rthr_r);
    up   = (d_y_r != '0) && flag_rd_r;
    left = (d_x_r != '0) && left_r;
    diag = (d_x_r != '0) && diag_r;
    case (mode_r)
      bdpb_pkg::MODE_SINGLE: begin
        blank = (10'(d_center_r) >= bthr_r) && (12'(d_ring1_r) <= rthr_r);
        found = blank;
      end
      bdpb_pkg::MODE_BLOCK: begin
        blank = cur || up || left || diag;
        found = cur;
      end
      default: begin
        blank = 1'b0;
        found = 1'b0;
      end
    endcase
    total_nxt = total_r;
    if (found && (total_r != bdpb_pkg::COUNT_MAX)) begin
      total_nxt = total_r + bdpb_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en && d_valid_r) begin
      flag_mem[d_x_r] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      left_r  <= 1'b0;
      diag_r  <= 1'b0;
      total_r <= '0;
    end else if (en && d_valid_r) begin
      left_r  <= cur;
      diag_r  <= up;
      total_r <= d_last_r ? '0 : total_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic [bdpb_pkg::PIX_W-1:0] out_pix_r;
  logic                       out_blank_r;
  logic                       out_last_r;
  logic [bdpb_pkg::CNT_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r   <= blank ? '0 : d_center_r;
      out_blank_r <= blank;
      out_last_r  <= d_last_r;
      out_count_r <= d_last_r ? total_nxt : '0;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.pixel_out    = out_pix_r;
  assign out_if.was_blanked  = out_blank_r;
  assign out_if.frame_last   = out_last_r;
  assign out_if.defect_count = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_flush_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && pix_phase && in_if.is_flush && !restart)
      |=> !b_valid_r)
    else $error("flush item in pixel phase entered the pipeline");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_cnt_r} < w_eff) || $past(restart) || $past(cfg_we))
    else $error("input column counter beyond frame width");

  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_blank_r) |-> (out_pix_r == '0))
    else $error("blanked item carries a nonzero pixel");

  a_count_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_count_r == '0))
    else $error("defect count shown outside frame end");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bright_defect_pixel_blanking_core. Frames of dark
// background with scattered bright spots and blocks are streamed through the
// core under many register settings. A built-in pixel predictor keeps its own
// copy of the row store, block flags and counters, and every result item is
// compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bdpb_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             blanked;
    logic             last;
    logic [CNT_W-1:0] count;
  } pix_result_t;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 1150;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bdpb_in_if  in_if ();
  bdpb_out_if out_if ();

  bright_defect_pixel_blanking_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Pending input items and the results that the predictor expects.
  pix_item_t   pending_pixels[$];
  pix_result_t expected_pixels[$];
  int error_count;
  int items_queued;
  int idle_cycles;

  // Predictor copy of the registers.
  logic [1:0]        pr_mode;
  logic [BTHR_W-1:0] pr_bright;
  logic [RTHR_W-1:0] pr_ring;
  logic [DIM_W-1:0]  pr_width;
  logic [DIM_W-1:0]  pr_height;

  // Predictor copy of the core state.
  logic [PIX_W-1:0] line_mem[4][MAX_WIDTH_DEF];
  bit               block_flags[MAX_WIDTH_DEF];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      defects_seen;
  bit               diag_prev;

  // Scratch image for frame generation.
  logic [PIX_W-1:0] img[4 * MAX_WIDTH_DEF];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append to the tail of the input and result queues.
  function automatic void add_pending(pix_item_t it);
    pending_pixels.insert(pending_pixels.size(), it);
  endfunction

  function automatic void add_expected(pix_result_t r);
    expected_pixels.insert(expected_pixels.size(), r);
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_w();
    return clamp_dim(pr_width, MAX_WIDTH_DEF);
  endfunction

  function automatic int unsigned eff_h();
    return clamp_dim(pr_height, HEIGHT_LIMIT);
  endfunction

  // Reflect a coordinate at the frame edge without repeating the edge pixel.
  function automatic int unsigned reflect(int i, int len);
    if (i < 0) i = -i;
    if (i >= len) i = 2 * len - 2 - i;
    return i;
  endfunction

  function automatic int unsigned stored_px(int x, int y);
    int unsigned cx;
    int unsigned cy;
    cx = reflect(x, eff_w());
    cy = reflect(y, eff_h());
    return line_mem[cy & 3][cx];
  endfunction

  // Block decision for the 2x2 block whose top-left pixel is (x,y).
  function automatic bit block_is_defect(int x, int y);
    int a;
    int b;
    int unsigned inner;
    int unsigned ring;
    int unsigned v;
    a = x + 1;
    b = y + 1;
    inner = 0;
    ring = 0;
    if (a > int'(eff_w()) - 1 || b > int'(eff_h()) - 1) return 1'b0;
    for (int dy = -2; dy <= 1; dy++) begin
      for (int dx = -2; dx <= 1; dx++) begin
        v = stored_px(a + dx, b + dy);
        if (dy == -2 || dy == 1 || dx == -2 || dx == 1) ring += v;
        else inner += v;
      end
    end
    return (inner >= pr_bright) && (ring <= pr_ring);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    defects_seen = 0;
    diag_prev = 1'b0;
  endfunction

  // Advance the predictor by one accepted item and queue any result it causes.
  function automatic void predict_pixel(logic [PIX_W-1:0] px, logic flush);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned lag;
    int unsigned t;
    int unsigned n;
    int unsigned x;
    int unsigned y;
    int unsigned orig;
    int unsigned ring;
    bit cur;
    bit up;
    bit left;
    bit diag;
    bit blank;
    bit found;
    pix_result_t r;
    w = eff_w();
    h = eff_h();
    total = w * h;
    lag = 2 * w + 2;
    t = row_pos * w + col_pos;
    if (t < total) begin
      // A flush item inside the pixel phase is dropped with no effect.
      if (flush) return;
      line_mem[row_pos & 3][col_pos] = px;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (t < lag) return;
    n = t - lag;
    x = n % w;
    y = n / w;
    orig = stored_px(x, y);
    cur = block_is_defect(x, y);
    up = (y >= 1) ? block_flags[x] : 1'b0;
    left = (x >= 1) ? block_flags[x - 1] : 1'b0;
    diag = (x >= 1) ? diag_prev : 1'b0;
    diag_prev = up;
    block_flags[x] = cur;
    if (pr_mode == MODE_SINGLE) begin
      ring = 0;
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++)
          if (dx != 0 || dy != 0) ring += stored_px(int'(x) + dx, int'(y) + dy);
      blank = (orig >= pr_bright) && (ring <= pr_ring);
      found = blank;
    end else if (pr_mode == MODE_BLOCK) begin
      blank = cur || up || left || diag;
      found = cur;
    end else begin
      blank = 1'b0;
      found = 1'b0;
    end
    if (found && defects_seen < COUNT_MAX) defects_seen++;
    r.pixel = blank ? '0 : orig[PIX_W-1:0];
    r.blanked = blank;
    r.last = (n == total - 1);
    r.count = r.last ? defects_seen[CNT_W-1:0] : '0;
    add_expected(r);
    if (r.last) restart_frame();
  endfunction

  function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_MODE: pr_mode = val[1:0];
      CFG_BTHR: pr_bright = val[BTHR_W-1:0];
      CFG_RTHR: pr_ring = val[RTHR_W-1:0];
      CFG_WIDTH: begin
        pr_width = val;
        restart_frame();
      end
      CFG_HEIGHT: begin
        pr_height = val;
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and whole stretches without any.
  function automatic int pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Input driver: accepts the current item, then offers the next one.
  int  send_gap;
  bit  send_quiet;
  int  send_run;
  always @(posedge clk) begin
    logic nv;
    logic [PIX_W-1:0] np;
    logic nf;
    pix_item_t it;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.pixel_in <= '0;
      in_if.is_flush <= 1'b0;
      send_gap <= 0;
      send_quiet <= 1'b0;
      send_run <= 0;
    end else begin
      nv = in_if.valid;
      np = in_if.pixel_in;
      nf = in_if.is_flush;
      if (in_if.valid && in_if.ready) begin
        predict_pixel(in_if.pixel_in, in_if.is_flush);
        nv = 1'b0;
        send_gap = pick_gap(send_quiet);
        send_run = send_run + 1;
        if (send_run >= 150) begin
          send_run = 0;
          send_quiet = ($urandom_range(3) == 0);
        end
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (pending_pixels.size() > 0) begin
          it = pending_pixels.pop_front();
          nv = 1'b1;
          np = it.pixel;
          nf = it.flush;
        end
      end
      in_if.valid <= nv;
      in_if.pixel_in <= np;
      in_if.is_flush <= nf;
    end
  end

  // Result monitor: checks each accepted result, then stalls at random.
  int  stall_left;
  bit  recv_quiet;
  int  recv_run;
  always @(posedge clk) begin
    pix_result_t exp_r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
      recv_quiet <= 1'b0;
      recv_run <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: pixel_out=%0d", out_if.pixel_out);
          error_count++;
        end else begin
          exp_r = expected_pixels.pop_front();
          if (out_if.pixel_out !== exp_r.pixel) begin
            $error("pixel_out expected %0d actual %0d", exp_r.pixel, out_if.pixel_out);
            error_count++;
          end
          if (out_if.was_blanked !== exp_r.blanked) begin
            $error("was_blanked expected %0d actual %0d", exp_r.blanked,
                   out_if.was_blanked);
            error_count++;
          end
          if (out_if.frame_last !== exp_r.last) begin
            $error("frame_last expected %0d actual %0d", exp_r.last, out_if.frame_last);
            error_count++;
          end
          if (out_if.defect_count !== exp_r.count) begin
            $error("defect_count expected %0d actual %0d", exp_r.count,
                   out_if.defect_count);
            error_count++;
          end
        end
        recv_run = recv_run + 1;
        if (recv_run >= 170) begin
          recv_run = 0;
          recv_quiet = ($urandom_range(3) == 0);
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        stall_left = pick_gap(recv_quiet);
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog: any long stretch with no handshake on either side is a hang.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_reg(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the sender until every queued item is in and every result is out.
  // A partial frame can still hold pixels in flight, so the task keeps waiting
  // before the registers are touched.
  task automatic drain_all();
    while (pending_pixels.size() > 0 || in_if.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly dark background with isolated bright pixels and bright 2x2 blocks.
  task automatic fill_image(int unsigned w, int unsigned h);
    int unsigned bg;
    int unsigned spots;
    int unsigned sx;
    int unsigned sy;
    case ($urandom_range(3))
      0: bg = 0;
      1: bg = 3;
      2: bg = 15;
      default: bg = ($urandom_range(4) == 0) ? 255 : 8;
    endcase
    for (int unsigned i = 0; i < w * h; i++) img[i] = $urandom_range(bg);
    spots = (w * h) / 12 + 1;
    for (int unsigned k = 0; k < spots; k++) begin
      sx = $urandom_range(w - 1);
      sy = $urandom_range(h - 1);
      if ($urandom_range(1) == 0) begin
        img[sy * w + sx] = $urandom_range(255, 150);
      end else begin
        for (int unsigned dy = 0; dy < 2; dy++)
          for (int unsigned dx = 0; dx < 2; dx++)
            if (sx + dx < w && sy + dy < h)
              img[(sy + dy) * w + sx + dx] = $urandom_range(255, 60);
      end
    end
  endtask

  // Queue the first npx pixels of the image; a whole frame also gets its
  // drain items. Stray flush items go into the pixel phase and stray pixels
  // into the drain phase.
  task automatic queue_frame(int unsigned w, int unsigned h, int unsigned npx);
    pix_item_t it;
    for (int unsigned i = 0; i < npx; i++) begin
      if ($urandom_range(99) < 3) begin
        it.pixel = $urandom;
        it.flush = 1'b1;
        add_pending(it);
        items_queued++;
      end
      it.pixel = img[i];
      it.flush = 1'b0;
      add_pending(it);
      items_queued++;
    end
    if (npx == w * h) begin
      for (int unsigned i = 0; i < 2 * w + 2; i++) begin
        it.pixel = $urandom;
        it.flush = ($urandom_range(99) < 80);
        add_pending(it);
        items_queued++;
      end
    end
  endtask

  task automatic random_phase();
    logic [1:0] m;
    logic [CFG_W-1:0] bv;
    logic [CFG_W-1:0] rv;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    int unsigned frames;
    case ($urandom_range(9))
      0: m = 2'd0;
      1: m = 2'd3;
      2, 3, 4, 5: m = MODE_SINGLE;
      default: m = MODE_BLOCK;
    endcase
    case ($urandom_range(19))
      0: bv = 0;
      1: bv = 1023;
      default: bv = (m == MODE_BLOCK) ? $urandom_range(900, 200) : $urandom_range(255, 100);
    endcase
    case ($urandom_range(19))
      0, 1: rv = 0;
      2: rv = 4095;
      default: rv = $urandom_range(150);
    endcase
    case ($urandom_range(9))
      0: wv = $urandom_range(3);
      1: wv = $urandom_range(16, 11);
      default: wv = $urandom_range(10, 4);
    endcase
    hv = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(7, 4);
    write_reg(CFG_MODE, m);
    write_reg(CFG_BTHR, bv);
    write_reg(CFG_RTHR, rv);
    if ($urandom_range(4) == 0) write_reg(CIDX_W'($urandom_range(7, 5)), $urandom);
    write_reg(CFG_WIDTH, wv);
    write_reg(CFG_HEIGHT, hv);
    end_writes();
    frames = $urandom_range(3, 1);
    for (int unsigned f = 0; f < frames; f++) begin
      fill_image(eff_w(), eff_h());
      queue_frame(eff_w(), eff_h(), eff_w() * eff_h());
    end
    // Sometimes stop partway through a frame; the next phase restarts it.
    if ($urandom_range(4) == 0) begin
      fill_image(eff_w(), eff_h());
      queue_frame(eff_w(), eff_h(), $urandom_range(eff_w() * eff_h() - 1, 1));
    end
    drain_all();
  endtask

  initial begin
    bit big_done;
    error_count = 0;
    items_queued = 0;
    idle_cycles = 0;
    big_done = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.pixel_in = '0;
    in_if.is_flush = 1'b0;
    out_if.ready = 1'b0;
    pr_mode = MODE_RST;
    pr_bright = BTHR_RST;
    pr_ring = RTHR_RST;
    pr_width = WIDTH_RST;
    pr_height = HEIGHT_RST;
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed frame: 4x4, single-pixel mode, a full-scale isolated pixel
    // that is blanked and a pixel one below the bright limit that is not.
    write_reg(CFG_MODE, MODE_SINGLE);
    write_reg(CFG_BTHR, 200);
    write_reg(CFG_RTHR, 0);
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_HEIGHT, 4);
    end_writes();
    for (int i = 0; i < 16; i++) img[i] = 8'd0;
    img[5] = 8'd255;
    img[15] = 8'd199;
    queue_frame(4, 4, 16);
    drain_all();

    while (items_queued < ITEM_TARGET) begin
      random_phase();
      // The start of a frame at the largest width, with both dimensions out
      // of range so that the clamps decide the frame shape. A whole frame
      // would be far too many items, so only its first pixels are sent and
      // the next phase restarts the frame.
      if (!big_done && items_queued > 500) begin
        big_done = 1'b1;
        write_reg(CFG_MODE, ($urandom_range(1) == 0) ? MODE_SINGLE : 2'd3);
        write_reg(CFG_BTHR, 1023);
        write_reg(CFG_RTHR, 4095);
        write_reg(CFG_WIDTH, 13'h1fff);
        write_reg(CFG_HEIGHT, 13'd0);
        end_writes();
        fill_image(eff_w(), eff_h());
        queue_frame(eff_w(), eff_h(), 300);
        drain_all();
      end
    end

    drain_all();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/bdpb_pkg.sv
sv/bdpb_if.sv
sv/bright_defect_pixel_blanking_core.sv
tb/tb.sv
